### src/gcor_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcor_pkg;

  // default geometry
  localparam int AXIS_BITS_DEF      = 4;
  localparam int SLOTS_PER_CELL_DEF = 16;

  // fixed field widths
  localparam int POS_W    = 4;
  localparam int HALF_W   = 3;
  localparam int HANDLE_W = 16;
  localparam int SLOT_W   = 4;
  localparam int ACTIVE_W = 13;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;

  // stream payload layout
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 40;

  // output field positions inside tdata
  localparam int OUT_SLOT_LSB   = 0;
  localparam int OUT_MV_LSB     = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_MH_LSB     = OUT_MV_LSB + 1;
  localparam int OUT_ACT_LSB    = OUT_MH_LSB + HANDLE_W;
  localparam int OUT_STATUS_LSB = OUT_ACT_LSB + ACTIVE_W;
  localparam int OUT_USED_W     = OUT_STATUS_LSB + STATUS_W;

  typedef enum logic {
    REQ_REGISTER   = 1'b0,
    REQ_UNREGISTER = 1'b1
  } gcor_req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_BADSLOT = 3'd3,
    STAT_OUTSIDE = 3'd4
  } gcor_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_HALF = 2'd0,
    CFG_Y_HALF = 2'd1,
    CFG_Z_HALF = 2'd2,
    CFG_NONE   = 2'd3
  } gcor_cfg_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MOVE
  } gcor_state_e;

  // signed position plus half extent, sign in bit 5
  function automatic logic [5:0] grid_offset(logic [POS_W-1:0] pos, logic [HALF_W-1:0] half);
    grid_offset = {{2{pos[POS_W-1]}}, pos} + {3'b000, half};
  endfunction

  // offset lies within 0 .. 2*half
  function automatic logic grid_in(logic [5:0] off, logic [HALF_W-1:0] half);
    grid_in = !off[5] && (off <= {2'b00, half, 1'b0});
  endfunction

endpackage

`default_nettype wire

### src/grid_cell_object_registry.sv
// result: a register request, or any request that fails, is answered from S_EXEC; an unregister
//   that frees a slot goes on to S_MOVE and is answered from there; tvalid is registered
// requests are taken one at a time, with tready high only in S_IDLE (read, then modify/write)
// reset: config halves go to 1, active total to 0; then a clearing pass over all NUM_CELLS
//   entries (4096 at the default geometry) zeroes the count memory with tready low
`timescale 1ns / 1ps
`default_nettype none

module grid_cell_object_registry
  import gcor_pkg::*;
#(
  parameter int AXIS_BITS      = AXIS_BITS_DEF,
  parameter int SLOTS_PER_CELL = SLOTS_PER_CELL_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [HALF_W-1:0]     cfg_data_i,
  // request stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // cell_x[3:0], cell_y[7:4], cell_z[11:8], object_handle[27:12], slot_index[31:28]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // req_type[0]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser_i,
  // result stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // assigned_slot[3:0], moved_valid[4], moved_handle[20:5], active_cells[33:21],
  // status[36:34], zero[39:37]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o
);

  localparam int CELL_BITS = 3 * AXIS_BITS;
  localparam int NUM_CELLS = 1 << CELL_BITS;
  localparam int SLOT_BITS = $clog2(SLOTS_PER_CELL);
  localparam int CNT_BITS  = $clog2(SLOTS_PER_CELL + 1);
  localparam int TOT_W     = CELL_BITS + 1;
  localparam int SIDX_W    = (CNT_BITS > SLOT_W) ? CNT_BITS : SLOT_W;
  localparam int SADDR_W   = CELL_BITS + SLOT_BITS;
  localparam int SMEM_D    = 1 << SADDR_W;
  localparam logic [5:0]          AXIS_SPAN = 6'(1 << AXIS_BITS);
  localparam logic [CNT_BITS-1:0] CNT_MAX   = CNT_BITS'(SLOTS_PER_CELL);

  // memories
  logic [CNT_BITS-1:0]  cnt_mem  [NUM_CELLS];
  logic [CELL_BITS-1:0] pos_mem  [NUM_CELLS];
  logic [CELL_BITS-1:0] list_mem [NUM_CELLS];
  logic [HANDLE_W-1:0]  slot_mem [SMEM_D];

  // config registers
  logic [HALF_W-1:0] half_x_q, half_y_q, half_z_q;

  // control state
  gcor_state_e          state_q, state_d;
  logic [CELL_BITS-1:0] clr_q, clr_d;
  logic [TOT_W-1:0]     total_q, total_d;
  logic                 move_q, move_d;
  logic                 m_valid_q;

  // request registers
  logic                 unreg_q;
  logic                 outside_q;
  logic [CELL_BITS-1:0] cell_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [SIDX_W-1:0]    slot_q;

  // read data
  logic [CNT_BITS-1:0]  cnt_rd_q;
  logic [CELL_BITS-1:0] pos_rd_q;
  logic [CELL_BITS-1:0] list_rd_q;
  logic [HANDLE_W-1:0]  slot_rd_q;

  // output register
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic                  m_load;

  // memory port controls
  logic                 cnt_we;
  logic [CELL_BITS-1:0] cnt_wa;
  logic [CNT_BITS-1:0]  cnt_wd;
  logic                 pos_we;
  logic [CELL_BITS-1:0] pos_wa;
  logic [CELL_BITS-1:0] pos_wd;
  logic                 list_we;
  logic [CELL_BITS-1:0] list_wa;
  logic [CELL_BITS-1:0] list_wd;
  logic                 slot_we;
  logic [SADDR_W-1:0]   slot_wa;
  logic [HANDLE_W-1:0]  slot_wd;
  logic                 slot_re;
  logic [SADDR_W-1:0]   slot_ra;

  // input decode
  logic                 s_fire;
  logic [5:0]           off_x, off_y, off_z;
  logic                 in_grid;
  logic [CELL_BITS-1:0] cell_in;
  logic [TOT_W-1:0]     tot_m1;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // grid coordinates and cell id from the incoming beat
  assign off_x = grid_offset(s_axis_tdata_i[3:0], half_x_q);
  assign off_y = grid_offset(s_axis_tdata_i[7:4], half_y_q);
  assign off_z = grid_offset(s_axis_tdata_i[11:8], half_z_q);
  assign in_grid = grid_in(off_x, half_x_q) && (off_x < AXIS_SPAN) &&
                   grid_in(off_y, half_y_q) && (off_y < AXIS_SPAN) &&
                   grid_in(off_z, half_z_q) && (off_z < AXIS_SPAN);
  assign cell_in = {off_z[AXIS_BITS-1:0], off_y[AXIS_BITS-1:0], off_x[AXIS_BITS-1:0]};
  assign tot_m1  = total_q - TOT_W'(1);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_x_q <= HALF_W'(1);
      half_y_q <= HALF_W'(1);
      half_z_q <= HALF_W'(1);
    end else if (cfg_we_i) begin
      unique case (gcor_cfg_e'(cfg_idx_i))
        CFG_X_HALF: half_x_q <= cfg_data_i;
        CFG_Y_HALF: half_y_q <= cfg_data_i;
        CFG_Z_HALF: half_z_q <= cfg_data_i;
        CFG_NONE:   ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      unreg_q   <= (gcor_req_e'(s_axis_tuser_i[0]) == REQ_UNREGISTER);
      outside_q <= !in_grid;
      cell_q    <= cell_in;
      handle_q  <= s_axis_tdata_i[27:12];
      slot_q    <= SIDX_W'(s_axis_tdata_i[31:28]);
    end
  end

  // count memory
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (s_fire) cnt_rd_q <= cnt_mem[cell_in];
  end

  // list position memory
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (s_fire) pos_rd_q <= pos_mem[cell_in];
  end

  // active cell list, read at the current tail
  always_ff @(posedge clk_i) begin
    if (list_we) list_mem[list_wa] <= list_wd;
    if (s_fire) list_rd_q <= list_mem[tot_m1[CELL_BITS-1:0]];
  end

  // slot store
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_rd_q <= slot_mem[slot_ra];
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      total_q <= '0;
      move_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      total_q <= total_d;
      move_q  <= move_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // next state, memory writes and result
  always_comb begin
    logic                go;
    logic                full;
    logic                bad_slot;
    logic [CNT_BITS-1:0] last;
    logic [TOT_W-1:0]    tot_dec;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_mv;
    logic [HANDLE_W-1:0] r_mh;
    gcor_status_e        r_status;

    go       = !m_valid_q || m_axis_tready_i;
    full     = (cnt_rd_q >= CNT_MAX);
    bad_slot = (slot_q >= SIDX_W'(cnt_rd_q));
    last     = cnt_rd_q - CNT_BITS'(1);
    tot_dec  = total_q - TOT_W'(1);

    state_d = state_q;
    clr_d   = clr_q;
    total_d = total_q;
    move_d  = move_q;
    m_load  = 1'b0;

    cnt_we  = 1'b0;
    cnt_wa  = cell_q;
    cnt_wd  = cnt_rd_q;
    pos_we  = 1'b0;
    pos_wa  = cell_q;
    pos_wd  = total_q[CELL_BITS-1:0];
    list_we = 1'b0;
    list_wa = total_q[CELL_BITS-1:0];
    list_wd = cell_q;
    slot_we = 1'b0;
    slot_wa = {cell_q, cnt_rd_q[SLOT_BITS-1:0]};
    slot_wd = handle_q;
    slot_re = 1'b0;
    slot_ra = {cell_q, last[SLOT_BITS-1:0]};

    r_slot   = '0;
    r_mv     = 1'b0;
    r_mh     = '0;
    r_status = STAT_OK;

    unique case (state_q)
      // zero the count memory one entry a cycle
      S_CLEAR: begin
        cnt_we = 1'b1;
        cnt_wa = clr_q;
        cnt_wd = '0;
        clr_d  = clr_q + CELL_BITS'(1);
        if (clr_q == '1) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (s_fire) state_d = S_EXEC;
      end

      // count and list data are in, decide and update
      S_EXEC: begin
        if (unreg_q && !outside_q && (cnt_rd_q != '0) && !bad_slot) begin
          // unregister that frees a slot: shrink the cell, fetch its last handle
          cnt_we  = 1'b1;
          cnt_wd  = last;
          slot_re = 1'b1;
          move_d  = (slot_q != SIDX_W'(last));
          state_d = S_MOVE;
          if ((last == '0) && (total_q != '0)) begin
            total_d = tot_dec;
            // swap-remove from the active list
            if ({1'b0, pos_rd_q} != tot_dec) begin
              list_we = 1'b1;
              list_wa = pos_rd_q;
              list_wd = list_rd_q;
              pos_we  = 1'b1;
              pos_wa  = list_rd_q;
              pos_wd  = pos_rd_q;
            end
          end
        end else if (go) begin
          m_load  = 1'b1;
          state_d = S_IDLE;
          if (outside_q) begin
            r_status = STAT_OUTSIDE;
          end else if (unreg_q) begin
            r_status = (cnt_rd_q == '0) ? STAT_EMPTY : STAT_BADSLOT;
          end else if (full) begin
            r_status = STAT_FULL;
          end else begin
            // register: append handle, activate an empty cell
            slot_we = 1'b1;
            cnt_we  = 1'b1;
            cnt_wd  = cnt_rd_q + CNT_BITS'(1);
            r_slot  = SLOT_W'(cnt_rd_q);
            if ((cnt_rd_q == '0) && !total_q[CELL_BITS]) begin
              list_we = 1'b1;
              pos_we  = 1'b1;
              total_d = total_q + TOT_W'(1);
            end
          end
        end
      end

      // move the last handle into the freed slot
      S_MOVE: begin
        if (go) begin
          m_load  = 1'b1;
          state_d = S_IDLE;
          if (move_q) begin
            slot_we = 1'b1;
            slot_wa = {cell_q, slot_q[SLOT_BITS-1:0]};
            slot_wd = slot_rd_q;
            r_mv    = 1'b1;
            r_mh    = slot_rd_q;
          end
        end
      end
    endcase

    m_data_d = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, r_status, ACTIVE_W'(total_d),
                r_mh, r_mv, r_slot};
  end

endmodule

`default_nettype wire

### src/gcor_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gcor_checker
  import gcor_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic                mv;
  logic [HANDLE_W-1:0] mh;

  assign status = m_axis_tdata_o[OUT_STATUS_LSB +: STATUS_W];
  assign slot   = m_axis_tdata_o[OUT_SLOT_LSB +: SLOT_W];
  assign mv     = m_axis_tdata_o[OUT_MV_LSB];
  assign mh     = m_axis_tdata_o[OUT_MH_LSB +: HANDLE_W];

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted on back-to-back cycles");

  // status code in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (status == STAT_OK) || (status == STAT_FULL) ||
      (status == STAT_EMPTY) || (status == STAT_BADSLOT) || (status == STAT_OUTSIDE))
    else $error("bad status code");

  // error results carry no slot and no moved handle
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (status != STAT_OK) |-> (slot == '0) && !mv && (mh == '0))
    else $error("error result carries payload");

  // no moved handle without moved flag
  a_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !mv |-> (mh == '0))
    else $error("moved handle without moved flag");

endmodule

bind grid_cell_object_registry gcor_checker u_gcor_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

### tb/sv/tb_grid_cell_object_registry.sv
`timescale 1ns / 1ps

module tb_grid_cell_object_registry;
  import gcor_pkg::*;

  localparam int NUM_CELLS       = 1 << (3 * AXIS_BITS_DEF);
  localparam int SLOTS           = SLOTS_PER_CELL_DEF;
  localparam int AXIS_SPAN       = 1 << AXIS_BITS_DEF;
  localparam int IDLE_LIMIT      = 12000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int NUM_PHASES      = 5;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int NOISE_PCT       = 15;

  typedef struct {
    gcor_req_e             kind;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [HANDLE_W-1:0]   handle;
    logic [SLOT_W-1:0]     slot;
  } req_t;

  typedef struct {
    logic [SLOT_W-1:0]   slot;
    logic                moved_valid;
    logic [HANDLE_W-1:0] moved_handle;
    logic [ACTIVE_W-1:0] active;
    gcor_status_e        status;
  } reply_t;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct {
    req_t   req;
    int     reps;
    bit     typed;
    reply_t exp;
  } row_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  // dut side signals
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_X_HALF;
  logic [HALF_W-1:0]     cfg_data = '0;
  logic                  s_valid  = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data   = '0;
  logic [IN_USER_W-1:0]  s_user   = '0;
  logic                  m_valid;
  logic                  m_ready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;

  grid_cell_object_registry i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    // cell_x, cell_y, cell_z, object_handle, slot_index
    .s_axis_tdata_i  (s_data),
    // req_type
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    // assigned_slot, moved_valid, moved_handle, active_cells, status, zero pad
    .m_axis_tdata_o  (m_data)
  );

  // registry mirror
  logic [HALF_W-1:0]   half_x = 3'd1;
  logic [HALF_W-1:0]   half_y = 3'd1;
  logic [HALF_W-1:0]   half_z = 3'd1;
  logic [4:0]          obj_count [NUM_CELLS];
  logic [HANDLE_W-1:0] slot_store [NUM_CELLS * SLOTS];
  logic [11:0]         occupied_list [NUM_CELLS];
  logic [11:0]         list_pos [NUM_CELLS];
  logic [ACTIVE_W-1:0] occupied_total = '0;

  reply_t pending_replies [$];
  int     fail_cnt    = 0;
  int     idle_cycles = 0;
  int     burst_left  = 0;
  int     stall_left  = 0;
  bit     gaps_on     = 1'b1;
  bit     stall_on    = 1'b1;

  // signed position plus half extent, false when off the grid
  function automatic bit grid_axis(logic [POS_W-1:0] raw, logic [HALF_W-1:0] half,
                                   output int g);
    int s;
    s = int'($signed(raw)) + int'(half);
    g = s;
    return (s >= 0) && (s <= 2 * int'(half)) && (s < AXIS_SPAN);
  endfunction

  function automatic bit cell_of(req_t r, output int cid);
    int gx, gy, gz;
    bit ok;
    ok  = grid_axis(r.x, half_x, gx) & grid_axis(r.y, half_y, gy) &
          grid_axis(r.z, half_z, gz);
    cid = gx + (gy << AXIS_BITS_DEF) + (gz << (2 * AXIS_BITS_DEF));
    return ok;
  endfunction

  // applies one request to the mirror and returns the reply it gives
  function automatic reply_t apply_request(req_t r);
    reply_t y;
    int cid, cnt, base, last, pos, moved;
    y.slot         = '0;
    y.moved_valid  = 1'b0;
    y.moved_handle = '0;
    y.status       = STAT_OK;
    if (!cell_of(r, cid)) begin
      y.status = STAT_OUTSIDE;
    end else begin
      cnt  = int'(obj_count[cid]);
      base = cid * SLOTS;
      if (r.kind == REQ_REGISTER) begin
        if (cnt >= SLOTS) begin
          y.status = STAT_FULL;
        end else begin
          // first handle puts the cell at the end of the occupied list
          if (cnt == 0 && occupied_total < NUM_CELLS) begin
            occupied_list[occupied_total] = 12'(cid);
            list_pos[cid] = 12'(occupied_total);
            occupied_total++;
          end
          slot_store[base + cnt] = r.handle;
          y.slot = SLOT_W'(cnt);
          obj_count[cid] = 5'(cnt + 1);
        end
      end else if (cnt == 0) begin
        y.status = STAT_EMPTY;
      end else if (int'(r.slot) >= cnt) begin
        y.status = STAT_BADSLOT;
      end else begin
        // last handle fills the freed slot
        last = cnt - 1;
        if (int'(r.slot) != last) begin
          slot_store[base + int'(r.slot)] = slot_store[base + last];
          y.moved_valid  = 1'b1;
          y.moved_handle = slot_store[base + last];
        end
        obj_count[cid] = 5'(last);
        // emptied cell leaves the list, the tail entry takes its place
        if (last == 0 && occupied_total > 0) begin
          pos = int'(list_pos[cid]);
          occupied_total--;
          if (pos != int'(occupied_total)) begin
            moved = int'(occupied_list[occupied_total]);
            occupied_list[pos] = 12'(moved);
            list_pos[moved] = 12'(pos);
          end
        end
      end
    end
    y.active = occupied_total;
    return y;
  endfunction

  function automatic row_t mk_row(gcor_req_e k, int x, int y, int z, int h, int s,
                                  int reps, bit typed, int act, gcor_status_e st);
    row_t w;
    w.req.kind         = k;
    w.req.x            = POS_W'(x);
    w.req.y            = POS_W'(y);
    w.req.z            = POS_W'(z);
    w.req.handle       = HANDLE_W'(h);
    w.req.slot         = SLOT_W'(s);
    w.reps             = reps;
    w.typed            = typed;
    w.exp.slot         = '0;
    w.exp.moved_valid  = 1'b0;
    w.exp.moved_handle = '0;
    w.exp.active       = ACTIVE_W'(act);
    w.exp.status       = st;
    return w;
  endfunction

  // request beat with burst gaps; mirror updated once the beat is taken
  task automatic issue(req_t r, bit typed, reply_t typed_exp);
    reply_t y;
    if (gaps_on && burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_valid <= 1'b1;
    s_data  <= {r.slot, r.handle, r.z, r.y, r.x};
    s_user  <= r.kind;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    y = apply_request(r);
    if (typed) begin
      pending_replies.push_back(typed_exp);
    end else begin
      pending_replies.push_back(y);
    end
    if (burst_left > 0) burst_left--;
  endtask

  // writes all half extents, plus the unused index, with the block idle
  task automatic set_extents(logic [HALF_W-1:0] hx, logic [HALF_W-1:0] hy,
                             logic [HALF_W-1:0] hz);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_NONE;
    cfg_data <= HALF_W'($urandom_range(0, 7));
    @(posedge clk_i);
    cfg_idx  <= CFG_X_HALF;
    cfg_data <= hx;
    @(posedge clk_i);
    cfg_idx  <= CFG_Y_HALF;
    cfg_data <= hy;
    @(posedge clk_i);
    cfg_idx  <= CFG_Z_HALF;
    cfg_data <= hz;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    half_x = hx;
    half_y = hy;
    half_z = hz;
  endtask

  task automatic wait_replies();
    s_valid <= 1'b0;
    burst_left = 0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // result side stall pattern
  always @(posedge clk_i) begin
    if (!stall_on) begin
      m_ready <= 1'b1;
    end else if (stall_left > 0) begin
      m_ready    <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 6);
    end
  end

  // reply checker
  always @(posedge clk_i) begin : reply_check
    reply_t want, got;
    if (rst_ni && m_valid && m_ready) begin
      got.slot         = m_data[OUT_SLOT_LSB +: SLOT_W];
      got.moved_valid  = m_data[OUT_MV_LSB];
      got.moved_handle = m_data[OUT_MH_LSB +: HANDLE_W];
      got.active       = m_data[OUT_ACT_LSB +: ACTIVE_W];
      got.status       = gcor_status_e'(m_data[OUT_STATUS_LSB +: STATUS_W]);
      if (pending_replies.size() == 0) begin
        $error("reply beat with no request outstanding");
        fail_cnt++;
      end else begin
        want = pending_replies.pop_front();
        if (got.slot !== want.slot) begin
          $error("assigned_slot: expected %0d, got %0d", want.slot, got.slot);
          fail_cnt++;
        end
        if (got.moved_valid !== want.moved_valid) begin
          $error("moved_valid: expected %0d, got %0d", want.moved_valid, got.moved_valid);
          fail_cnt++;
        end
        if (got.moved_handle !== want.moved_handle) begin
          $error("moved_handle: expected %0d, got %0d", want.moved_handle,
                 got.moved_handle);
          fail_cnt++;
        end
        if (got.active !== want.active) begin
          $error("active_cells: expected %0d, got %0d", want.active, got.active);
          fail_cnt++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    row_t   rows [$];
    row_t   blank;
    req_t   r;
    reply_t unused;
    logic signed [POS_W-1:0] px [3];
    logic signed [POS_W-1:0] py [3];
    logic signed [POS_W-1:0] pz [3];
    logic [HALF_W-1:0] hx, hy, hz;
    int cid, j, reg_pct;

    foreach (obj_count[i]) obj_count[i] = '0;
    blank  = mk_row(REQ_REGISTER, 0, 0, 0, 0, 0, 1, 0, 0, STAT_OK);
    unused = blank.exp;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table at reset extents of one
    rows.push_back(mk_row(REQ_UNREGISTER,  0,  0,  0, 16'hFFFF,  0,  1, 1, 0, STAT_EMPTY));
    rows.push_back(mk_row(REQ_REGISTER,   -1, -1, -1, 16'hFFFF, 15,  1, 1, 1, STAT_OK));
    rows.push_back(mk_row(REQ_REGISTER,    1,  1,  1, 16'h0000,  0,  1, 1, 2, STAT_OK));
    rows.push_back(mk_row(REQ_REGISTER,    2,  0,  0, 16'h1234,  0,  1, 1, 2, STAT_OUTSIDE));
    rows.push_back(mk_row(REQ_UNREGISTER,  0, -2,  0, 16'h0000,  0,  1, 1, 2, STAT_OUTSIDE));
    rows.push_back(mk_row(REQ_REGISTER,    0,  0, -8, 16'h0001,  0,  1, 1, 2, STAT_OUTSIDE));
    rows.push_back(mk_row(REQ_REGISTER,    7, -7,  7, 16'h8000,  8,  1, 1, 2, STAT_OUTSIDE));
    rows.push_back(mk_row(REQ_REGISTER,    0,  0,  0, 16'h1000,  0, 16, 0, 0, STAT_OK));
    rows.push_back(mk_row(REQ_REGISTER,    0,  0,  0, 16'h2000,  0,  1, 1, 3, STAT_FULL));
    rows.push_back(mk_row(REQ_UNREGISTER,  0,  0,  0, 16'hABCD, 15,  1, 1, 3, STAT_OK));
    rows.push_back(mk_row(REQ_UNREGISTER,  0,  0,  0, 16'h0000, 15,  1, 1, 3, STAT_BADSLOT));
    rows.push_back(mk_row(REQ_UNREGISTER,  0,  0,  0, 16'h0000,  0,  1, 0, 0, STAT_OK));
    rows.push_back(mk_row(REQ_UNREGISTER, -1, -1, -1, 16'h0000,  0,  1, 0, 0, STAT_OK));
    rows.push_back(mk_row(REQ_UNREGISTER, -1, -1, -1, 16'h0000,  0,  1, 1, 2, STAT_EMPTY));
    rows.push_back(mk_row(REQ_UNREGISTER,  0,  0,  0, 16'h0000,  7,  1, 0, 0, STAT_OK));
    rows.push_back(mk_row(REQ_UNREGISTER,  1,  1,  1, 16'h0000,  1,  1, 1, 2, STAT_BADSLOT));
    rows.push_back(mk_row(REQ_UNREGISTER,  1,  1,  1, 16'h0000,  0,  1, 0, 0, STAT_OK));
    rows.push_back(mk_row(REQ_REGISTER,    1, -1,  0, 16'h5555,  0,  1, 0, 0, STAT_OK));
    rows.push_back(mk_row(REQ_UNREGISTER,  0,  0,  0, 16'h0000,  0, 13, 0, 0, STAT_OK));

    foreach (rows[i]) begin
      for (int k = 0; k < rows[i].reps; k++) begin
        r = rows[i].req;
        r.handle = HANDLE_W'(int'(r.handle) + k);
        issue(r, rows[i].typed, rows[i].exp);
      end
    end

    // random phases, each with its own extents and a small pool of busy cells
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_replies();
      case (p)
        0: begin hx = 3'd0; hy = 3'd0; hz = 3'd0; end
        1: begin hx = 3'd7; hy = 3'd7; hz = 3'd7; end
        2: begin hx = 3'd2; hy = 3'd0; hz = 3'd5; end
        default: begin
          hx = HALF_W'($urandom_range(0, 7));
          hy = HALF_W'($urandom_range(0, 7));
          hz = HALF_W'($urandom_range(0, 7));
        end
      endcase
      set_extents(hx, hy, hz);
      gaps_on  = $urandom_range(0, 2) != 0;
      stall_on = $urandom_range(0, 2) != 0;
      for (int q = 0; q < 3; q++) begin
        px[q] = POS_W'(int'($urandom_range(0, 2 * hx)) - int'(hx));
        py[q] = POS_W'(int'($urandom_range(0, 2 * hy)) - int'(hy));
        pz[q] = POS_W'(int'($urandom_range(0, 2 * hz)) - int'(hz));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // fill the pool first, then drain it
        reg_pct  = (n < ITEMS_PER_PHASE / 2) ? 70 : 30;
        r.handle = HANDLE_W'($urandom_range(0, 65535));
        r.slot   = SLOT_W'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < NOISE_PCT) begin
          r.kind = gcor_req_e'($urandom_range(0, 1));
          r.x    = POS_W'($urandom_range(0, 15));
          r.y    = POS_W'($urandom_range(0, 15));
          r.z    = POS_W'($urandom_range(0, 15));
        end else begin
          j      = $urandom_range(0, 2);
          r.x    = px[j];
          r.y    = py[j];
          r.z    = pz[j];
          r.kind = ($urandom_range(0, 99) < reg_pct) ? REQ_REGISTER : REQ_UNREGISTER;
          // mostly pick a slot that is in use
          if (r.kind == REQ_UNREGISTER && cell_of(r, cid) && obj_count[cid] != 0 &&
              $urandom_range(0, 9) != 0)
            r.slot = SLOT_W'($urandom_range(0, int'(obj_count[cid]) - 1));
        end
        issue(r, 1'b0, unused);
      end
    end

    // drain and settle
    wait_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
